>>> design/hbps_pkg.sv
// hbps_pkg: item types, register indexes and the hilbert quadrant step
// for the hilbert block pixel scatter; no dependencies
`default_nettype none

package hbps_pkg;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned X_W        = 12;
  localparam int unsigned Y_W        = 20;
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned SIDE_REG_W = 5;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIDE  = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic               first_of_image;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_pixel;
    logic [X_W-1:0]     out_x;
    logic [Y_W-1:0]     out_y;
    logic               overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    ORIENT_UP    = 2'd0,
    ORIENT_DOWN  = 2'd1,
    ORIENT_LEFT  = 2'd2,
    ORIENT_RIGHT = 2'd3
  } orient_t;

  typedef struct packed {
    logic    x;
    logic    y;
    orient_t next;
  } quad_t;

  // one level of the curve: quadrant digit under an orientation
  function automatic quad_t quad_step(input orient_t orient, input logic [1:0] d);
    quad_t q;
    logic [3:0] xv;
    logic [3:0] yv;
    xv = 4'b0000;
    yv = 4'b0000;
    q.next = ORIENT_UP;
    unique case (orient)
      ORIENT_UP: begin
        xv = 4'b1100;
        yv = 4'b0110;
        unique case (d)
          2'd0: q.next = ORIENT_LEFT;
          2'd1: q.next = ORIENT_UP;
          2'd2: q.next = ORIENT_UP;
          default: q.next = ORIENT_RIGHT;
        endcase
      end
      ORIENT_DOWN: begin
        xv = 4'b0011;
        yv = 4'b1001;
        unique case (d)
          2'd0: q.next = ORIENT_RIGHT;
          2'd1: q.next = ORIENT_DOWN;
          2'd2: q.next = ORIENT_DOWN;
          default: q.next = ORIENT_LEFT;
        endcase
      end
      ORIENT_LEFT: begin
        xv = 4'b0110;
        yv = 4'b1100;
        unique case (d)
          2'd0: q.next = ORIENT_UP;
          2'd1: q.next = ORIENT_LEFT;
          2'd2: q.next = ORIENT_LEFT;
          default: q.next = ORIENT_DOWN;
        endcase
      end
      default: begin
        xv = 4'b1001;
        yv = 4'b0011;
        unique case (d)
          2'd0: q.next = ORIENT_DOWN;
          2'd1: q.next = ORIENT_RIGHT;
          2'd2: q.next = ORIENT_RIGHT;
          default: q.next = ORIENT_UP;
        endcase
      end
    endcase
    q.x = xv[d];
    q.y = yv[d];
    return q;
  endfunction

endpackage

`default_nettype wire

>>> design/hilbert_block_pixel_scatter.sv
// hilbert_block_pixel_scatter: counts pixels through blocks, curve and squares
// and forms each pixel's output coordinate; depends on hbps_pkg
// path: an accepted item is registered in the first stage, then in dst_item
// throughput: one item per cycle unless stalled; counters advance at accept,
//   coordinate (curve walk plus two small multiplies) forms in second stage
// reset: synchronous rst clears counters, overflow flag and both valids;
//   curve_level and side_cfg return to 1
`default_nettype none

module hilbert_block_pixel_scatter #(
  parameter int unsigned MAX_LEVEL      = 8,
  parameter int unsigned MAX_BLOCK_SIDE = 16,
  parameter int unsigned MAX_SQUARES    = 256,
  parameter int unsigned PIXEL_BITS     = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           src_valid,
  output      logic                           src_stall,
  input  wire hbps_pkg::in_item_t             src_item,
  output      logic                           dst_valid,
  input  wire logic                           dst_stall,
  output      hbps_pkg::out_item_t            dst_item,
  input  wire logic                           cfg_write,
  input  wire logic [hbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hbps_pkg::CFG_W-1:0]     cfg_data
);

  localparam int unsigned SIDE_W = (MAX_BLOCK_SIDE > 1) ? $clog2(MAX_BLOCK_SIDE) : 1;
  localparam int unsigned SQ_W   = (MAX_SQUARES > 1) ? $clog2(MAX_SQUARES) : 1;
  localparam int unsigned IDX_W  = 2 * MAX_LEVEL;
  localparam int unsigned CW     = ((SIDE_W > hbps_pkg::SIDE_REG_W) ?
                                    SIDE_W : hbps_pkg::SIDE_REG_W) + 1;
  localparam int unsigned XW     = (MAX_LEVEL + 6 > hbps_pkg::X_W) ?
                                   MAX_LEVEL + 6 : hbps_pkg::X_W;
  localparam int unsigned BW     = SQ_W + MAX_LEVEL + 1;
  localparam int unsigned YW     = (BW + 6 > hbps_pkg::Y_W) ? BW + 6 : hbps_pkg::Y_W;
  localparam logic [hbps_pkg::PIXEL_W-1:0] PIX_MASK =
    (PIXEL_BITS >= hbps_pkg::PIXEL_W) ? '1 :
    hbps_pkg::PIXEL_W'((64'd1 << PIXEL_BITS) - 64'd1);

  // configuration
  logic [hbps_pkg::LEVEL_W-1:0]    curve_level;
  logic [hbps_pkg::SIDE_REG_W-1:0] side_cfg;
  logic [hbps_pkg::LEVEL_W-1:0]    level_eff;
  logic [hbps_pkg::SIDE_REG_W-1:0] side_eff;

  // image counters
  logic [SIDE_W-1:0] col_in_block, col_in_block_next;
  logic [SIDE_W-1:0] row_in_block, row_in_block_next;
  logic [IDX_W-1:0]  curve_index, curve_index_next;
  logic [SQ_W-1:0]   square_index, square_index_next;
  logic              square_overflow, square_overflow_next;

  // first stage: pixel with the counter values it is placed at
  logic                         s1_valid;
  logic [hbps_pkg::PIXEL_W-1:0] s1_pixel;
  logic [SIDE_W-1:0]            s1_col;
  logic [SIDE_W-1:0]            s1_row;
  logic [IDX_W-1:0]             s1_curve;
  logic [SQ_W-1:0]              s1_square;
  logic                         s1_ovf;

  logic src_take, s1_move, dst_ready;

  // counter snapshot after an optional restart
  logic [SIDE_W-1:0] base_col, base_row;
  logic [IDX_W-1:0]  base_curve;
  logic [SQ_W-1:0]   base_square;
  logic              base_ovf;
  logic              col_last, row_last, curve_last, square_last;
  logic [IDX_W:0]    points;

  // coordinate forming
  logic [MAX_LEVEL-1:0] bx, by;
  hbps_pkg::orient_t    orient;
  hbps_pkg::quad_t      q;
  logic [XW-1:0]        x_full;
  logic [BW-1:0]        y_base;
  logic [YW-1:0]        y_full;

  assign dst_ready = !dst_valid || !dst_stall;
  assign s1_move   = s1_valid && dst_ready;
  assign src_stall = s1_valid && !dst_ready;
  assign src_take  = src_valid && !src_stall;

  always_comb begin
    level_eff = curve_level;
    if (curve_level == '0) begin
      level_eff = hbps_pkg::LEVEL_W'(1);
    end else if (32'(curve_level) > 32'(MAX_LEVEL)) begin
      level_eff = hbps_pkg::LEVEL_W'(MAX_LEVEL);
    end
    side_eff = side_cfg;
    if (side_cfg == '0) begin
      side_eff = hbps_pkg::SIDE_REG_W'(1);
    end else if (32'(side_cfg) > 32'(MAX_BLOCK_SIDE)) begin
      side_eff = hbps_pkg::SIDE_REG_W'(MAX_BLOCK_SIDE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_level <= hbps_pkg::LEVEL_W'(1);
      side_cfg    <= hbps_pkg::SIDE_REG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        hbps_pkg::REG_CURVE_LEVEL: curve_level <= cfg_data[hbps_pkg::LEVEL_W-1:0];
        default:                   side_cfg    <= cfg_data[hbps_pkg::SIDE_REG_W-1:0];
      endcase
    end
  end

  // counter advance
  always_comb begin
    if (src_item.first_of_image) begin
      base_col    = '0;
      base_row    = '0;
      base_curve  = '0;
      base_square = '0;
      base_ovf    = 1'b0;
    end else begin
      base_col    = col_in_block;
      base_row    = row_in_block;
      base_curve  = curve_index;
      base_square = square_index;
      base_ovf    = square_overflow;
    end

    points      = (IDX_W+1)'(1) << {level_eff, 1'b0};
    col_last    = (CW'(base_col) + CW'(1)) >= CW'(side_eff);
    row_last    = (CW'(base_row) + CW'(1)) >= CW'(side_eff);
    curve_last  = ((IDX_W+1)'(base_curve) + (IDX_W+1)'(1)) >= points;
    square_last = (32'(base_square) + 32'd1) >= 32'(MAX_SQUARES);

    col_in_block_next    = base_col;
    row_in_block_next    = base_row;
    curve_index_next     = base_curve;
    square_index_next    = base_square;
    square_overflow_next = base_ovf;
    // counters freeze once the square count has run out
    if (!base_ovf) begin
      if (!col_last) begin
        col_in_block_next = base_col + SIDE_W'(1);
      end else begin
        col_in_block_next = '0;
        if (!row_last) begin
          row_in_block_next = base_row + SIDE_W'(1);
        end else begin
          row_in_block_next = '0;
          if (!curve_last) begin
            curve_index_next = base_curve + IDX_W'(1);
          end else begin
            curve_index_next = '0;
            if (!square_last) begin
              square_index_next = base_square + SQ_W'(1);
            end else begin
              square_overflow_next = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_in_block    <= '0;
      row_in_block    <= '0;
      curve_index     <= '0;
      square_index    <= '0;
      square_overflow <= 1'b0;
    end else if (src_take) begin
      col_in_block    <= col_in_block_next;
      row_in_block    <= row_in_block_next;
      curve_index     <= curve_index_next;
      square_index    <= square_index_next;
      square_overflow <= square_overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      s1_pixel  <= src_item.pixel_value & PIX_MASK;
      s1_col    <= base_col;
      s1_row    <= base_row;
      s1_curve  <= base_curve;
      s1_square <= base_square;
      s1_ovf    <= base_ovf;
    end
  end

  // curve index to block position, most significant digit first
  always_comb begin
    bx     = '0;
    by     = '0;
    orient = hbps_pkg::ORIENT_LEFT;
    q      = '0;
    for (int k = MAX_LEVEL - 1; k >= 0; k--) begin
      if (k < int'(level_eff)) begin
        q      = hbps_pkg::quad_step(orient, s1_curve[2*k +: 2]);
        bx[k]  = q.x;
        by[k]  = q.y;
        orient = q.next;
      end
    end
    x_full = XW'(bx) * XW'(side_eff) + XW'(s1_col);
    y_base = (BW'(s1_square) << level_eff) + BW'(by);
    y_full = YW'(y_base) * YW'(side_eff) + YW'(s1_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (dst_ready) begin
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      dst_item.out_pixel <= s1_pixel;
      dst_item.overflow  <= s1_ovf;
      if (s1_ovf) begin
        dst_item.out_x <= '1;
        dst_item.out_y <= '1;
      end else begin
        dst_item.out_x <= x_full[hbps_pkg::X_W-1:0];
        dst_item.out_y <= y_full[hbps_pkg::Y_W-1:0];
      end
    end
  end

  // a saturated result carries all-ones coordinates
  a_ovf_saturates: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_item.overflow) |-> (&dst_item.out_x && &dst_item.out_y))
    else $error("overflow result without saturated coordinate");

  // input is held off only while the first stage is full
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> s1_valid)
    else $error("input stalled with empty first stage");

  // after overflow the counters stay frozen until a new image
  a_ovf_freezes: assert property (@(posedge clk) disable iff (rst)
    (src_take && square_overflow && !src_item.first_of_image) |=>
    (square_overflow && col_in_block == $past(col_in_block) &&
     curve_index == $past(curve_index) && square_index == $past(square_index)))
    else $error("counters moved after overflow");

  // a restarted image places its first item at the origin
  a_first_at_origin: assert property (@(posedge clk) disable iff (rst)
    src_take && src_item.first_of_image |=>
    (s1_col == '0 && s1_row == '0 && s1_curve == '0 && s1_square == '0 && !s1_ovf))
    else $error("first item of image not at origin");

  // first stage moves on whenever the output register is free
  a_s1_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && dst_ready && !src_take) |=> !s1_valid)
    else $error("first stage held with free output");

endmodule

`default_nettype wire

>>> bench/hilbert_block_pixel_scatter_tb.sv
// hilbert_block_pixel_scatter_tb: self-checking bench that streams pixels into the scatter block
// and compares each placed pixel with a local model of the block, hilbert curve walk included
// depends on hbps_pkg and hilbert_block_pixel_scatter
`default_nettype none

module hilbert_block_pixel_scatter_tb;

  localparam int unsigned LEVEL_CAP    = 8;
  localparam int unsigned SIDE_CAP     = 16;
  localparam int unsigned SQUARE_COUNT = 256;
  localparam int          QUIET_LIMIT  = 1000;
  localparam int          HOLD_CYCLES  = 80;

  logic                           clk;
  logic                           rst;
  logic                           src_valid;
  logic                           src_stall;
  hbps_pkg::in_item_t             src_item;
  logic                           dst_valid;
  logic                           dst_stall = 1'b0;
  hbps_pkg::out_item_t            dst_item;
  logic                           cfg_write;
  logic [hbps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hbps_pkg::CFG_W-1:0]     cfg_data;

  hilbert_block_pixel_scatter dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // model copy of registers and counters
  int unsigned lvl_reg     = 1;
  int unsigned side_reg    = 1;
  int unsigned blk_col     = 0;
  int unsigned blk_row     = 0;
  int unsigned curve_pos   = 0;
  int unsigned square_num  = 0;
  bit          square_full = 1'b0;

  hbps_pkg::out_item_t placed_q[$];
  int        mismatch_count = 0;
  int        src_idle_pct   = 0;
  int        dst_stall_pct  = 0;
  int        hold_requests  = 0;
  int        hold_seen      = 0;
  int        hold_left      = 0;
  int        quiet_cycles   = 0;

  // where one pixel lands, then advance the counters
  function automatic hbps_pkg::out_item_t scatter_pixel(hbps_pkg::in_item_t it);
    hbps_pkg::out_item_t r;
    int unsigned         lvl;
    int unsigned         side;
    int unsigned         bx;
    int unsigned         by;
    logic [1:0]          digit;
    logic [3:0]          xs;
    logic [3:0]          ys;
    hbps_pkg::orient_t   dir;
    hbps_pkg::orient_t   turn0;
    hbps_pkg::orient_t   turn3;
    longint unsigned     xc;
    longint unsigned     yc;
    lvl  = (lvl_reg < 1) ? 1 : (lvl_reg > LEVEL_CAP) ? LEVEL_CAP : lvl_reg;
    side = (side_reg < 1) ? 1 : (side_reg > SIDE_CAP) ? SIDE_CAP : side_reg;
    if (it.first_of_image) begin
      blk_col     = 0;
      blk_row     = 0;
      curve_pos   = 0;
      square_num  = 0;
      square_full = 1'b0;
    end
    r.out_pixel = it.pixel_value;
    if (square_full) begin
      r.out_x    = '1;
      r.out_y    = '1;
      r.overflow = 1'b1;
      return r;
    end
    bx  = 0;
    by  = 0;
    dir = hbps_pkg::ORIENT_LEFT;
    for (int k = lvl; k > 0; k--) begin
      digit = 2'((curve_pos >> (2 * (k - 1))) & 3);
      // digits 1 and 2 keep the orientation, 0 and 3 turn it
      case (dir)
        hbps_pkg::ORIENT_UP: begin
          xs = 4'b1100; ys = 4'b0110;
          turn0 = hbps_pkg::ORIENT_LEFT;  turn3 = hbps_pkg::ORIENT_RIGHT;
        end
        hbps_pkg::ORIENT_DOWN: begin
          xs = 4'b0011; ys = 4'b1001;
          turn0 = hbps_pkg::ORIENT_RIGHT; turn3 = hbps_pkg::ORIENT_LEFT;
        end
        hbps_pkg::ORIENT_LEFT: begin
          xs = 4'b0110; ys = 4'b1100;
          turn0 = hbps_pkg::ORIENT_UP;    turn3 = hbps_pkg::ORIENT_DOWN;
        end
        default: begin
          xs = 4'b1001; ys = 4'b0011;
          turn0 = hbps_pkg::ORIENT_DOWN;  turn3 = hbps_pkg::ORIENT_UP;
        end
      endcase
      bx  = bx | (int'(xs[digit]) << (k - 1));
      by  = by | (int'(ys[digit]) << (k - 1));
      dir = (digit == 2'd0) ? turn0 : (digit == 2'd3) ? turn3 : dir;
    end
    xc = bx;
    xc = xc * side + blk_col;
    yc = square_num;
    yc = ((yc << lvl) + by) * side + blk_row;
    r.out_x    = xc[hbps_pkg::X_W-1:0];
    r.out_y    = yc[hbps_pkg::Y_W-1:0];
    r.overflow = 1'b0;
    if (blk_col + 1 < side) begin
      blk_col++;
    end else begin
      blk_col = 0;
      if (blk_row + 1 < side) begin
        blk_row++;
      end else begin
        blk_row = 0;
        if (curve_pos + 1 < (1 << (2 * lvl))) begin
          curve_pos++;
        end else begin
          curve_pos = 0;
          if (square_num + 1 < SQUARE_COUNT) begin
            square_num++;
          end else begin
            square_full = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic log_mismatch(input string why, input hbps_pkg::out_item_t want,
                              input hbps_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s): expected pixel %h x %0d y %0d ovf %0b,",
               why, want.out_pixel, want.out_x, want.out_y, want.overflow);
      $display("  got pixel %h x %0d y %0d ovf %0b",
               got.out_pixel, got.out_x, got.out_y, got.overflow);
    end
  endtask

  always @(posedge clk) begin : check_placement
    hbps_pkg::out_item_t want;
    if (!rst && dst_valid && !dst_stall) begin
      if (placed_q.size() == 0) begin
        log_mismatch("no item expected", '0, dst_item);
      end else begin
        want = placed_q.pop_front();
        if (dst_item.out_pixel !== want.out_pixel || dst_item.out_x !== want.out_x ||
            dst_item.out_y !== want.out_y || dst_item.overflow !== want.overflow) begin
          log_mismatch("field", want, dst_item);
        end
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      dst_stall <= 1'b1;
    end else begin
      dst_stall <= ($urandom_range(99) < dst_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [hbps_pkg::PIXEL_W-1:0] value, input logic restart);
    hbps_pkg::in_item_t it;
    it.pixel_value    = value;
    it.first_of_image = restart;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    placed_q.push_back(scatter_pixel(it));
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    do @(posedge clk); while (placed_q.size() != 0);
  endtask

  task automatic write_reg(input logic [hbps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hbps_pkg::CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == hbps_pkg::REG_CURVE_LEVEL) begin
      lvl_reg = value[hbps_pkg::LEVEL_W-1:0];
    end else begin
      side_reg = value;
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [hbps_pkg::CFG_W-1:0] lvl,
                            input logic [hbps_pkg::CFG_W-1:0] side);
    write_reg(hbps_pkg::REG_CURVE_LEVEL, lvl);
    write_reg(hbps_pkg::REG_BLOCK_SIDE, side);
  endtask

  task automatic test_reset_values();
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'hA5A5_5A5A, 1'b0);
    send_pixel(32'h5A5A_A5A5, 1'b0);
    send_pixel(32'h8000_0001, 1'b0);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // out of range values saturate, level keeps only its low four bits
    set_config(5'd15, 5'd31);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel($urandom, 1'b0);
    wait_drained();
    set_config(5'd0, 5'd0);
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
    send_pixel($urandom, 1'b0);
    wait_drained();
    set_config(5'b10010, 5'd17);
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
    send_pixel($urandom, 1'b0);
    wait_drained();
    set_config(hbps_pkg::CFG_W'(LEVEL_CAP), hbps_pkg::CFG_W'(SIDE_CAP));
    send_pixel($urandom, 1'b1);
    send_pixel($urandom, 1'b0);
    wait_drained();
  endtask

  task automatic test_reconfig_mid_image();
    set_config(5'd3, 5'd1);
    send_pixel($urandom, 1'b1);
    repeat (6) send_pixel($urandom, 1'b0);
    wait_drained();
    // curve index now above the smaller curve, column equal to the new side later
    set_config(5'd1, 5'd2);
    repeat (5) send_pixel($urandom, 1'b0);
    wait_drained();
    write_reg(hbps_pkg::REG_BLOCK_SIDE, 5'd1);
    repeat (2) send_pixel($urandom, 1'b0);
    wait_drained();
  endtask

  task automatic test_square_overflow();
    set_config(5'd1, 5'd1);
    send_pixel($urandom, 1'b1);
    repeat (SQUARE_COUNT * 4 + 2) send_pixel($urandom, 1'b0);
    send_pixel($urandom, 1'b1);
    repeat (3) send_pixel($urandom, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_phase(input int src_pct, input int dst_pct, input int count);
    int                         sent;
    int                         chunk;
    int unsigned                pick;
    logic [hbps_pkg::CFG_W-1:0] lvl;
    logic [hbps_pkg::CFG_W-1:0] side;
    src_idle_pct  = src_pct;
    dst_stall_pct = dst_pct;
    sent = 0;
    while (sent < count) begin
      wait_drained();
      lvl  = ($urandom_range(9) == 0) ? hbps_pkg::CFG_W'($urandom_range(31)) :
                                        hbps_pkg::CFG_W'($urandom_range(1, 3));
      side = ($urandom_range(9) == 0) ? hbps_pkg::CFG_W'($urandom_range(31)) :
                                        hbps_pkg::CFG_W'($urandom_range(1, 4));
      pick = $urandom_range(3);
      if (pick == 0) begin
        write_reg(hbps_pkg::REG_CURVE_LEVEL, lvl);
      end else if (pick == 1) begin
        write_reg(hbps_pkg::REG_BLOCK_SIDE, side);
      end else begin
        set_config(lvl, side);
      end
      chunk = $urandom_range(8, 24);
      // about half start a new image, the rest continue across the register change
      send_pixel($urandom, 1'($urandom_range(1)));
      for (int i = 1; i < chunk; i++) begin
        send_pixel($urandom, $urandom_range(99) < 2);
      end
      sent += chunk;
    end
    wait_drained();
  endtask

  task automatic test_output_hold();
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    wait_drained();
    hold_requests++;
    repeat (30) send_pixel($urandom, 1'b0);
    wait_drained();
  endtask

  initial begin
    rst       <= 1'b1;
    src_valid <= 1'b0;
    src_item  <= '0;
    cfg_write <= 1'b0;
    cfg_index <= hbps_pkg::REG_CURVE_LEVEL;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_register_extremes();
    test_reconfig_mid_image();
    test_square_overflow();
    test_random_phase(0, 0, 30);
    test_random_phase(70, 0, 30);
    test_random_phase(0, 70, 30);
    test_random_phase(23, 23, 30);
    test_output_hold();
    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && placed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/hbps_pkg.sv
design/hilbert_block_pixel_scatter.sv
bench/hilbert_block_pixel_scatter_tb.sv
